[hdl/pid_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_pkg
// Types, codes and saturating helpers shared by the polynomial integrator.
// ----------------------------------------------------------------------------
package pid_pkg;

  // Width of the rounded division count (13-bit request plus one for rounding).
  localparam int CNT_W = 14;
  localparam int PROD_W = 128;

  localparam logic [1:0] OP_TRAP = 2'd1;
  localparam logic [1:0] OP_SIMP = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_ZERO_N = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  localparam logic [1:0] REG_CUBIC    = 2'd0;
  localparam logic [1:0] REG_SQUARE   = 2'd1;
  localparam logic [1:0] REG_LINEAR   = 2'd2;
  localparam logic [1:0] REG_CONSTANT = 2'd3;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic [12:0]        divisions;
    logic [1:0]         opcode;
  } in_t;

  typedef struct packed {
    logic signed [63:0] integral;
    logic [12:0]        divisions_used;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_H2,
    CMD_H2_DONE,
    CMD_POINT,
    CMD_MUL,
    CMD_MUL_ADD,
    CMD_DOUBLE,
    CMD_ACC,
    CMD_SCALE_MUL,
    CMD_SCALE_DIV,
    CMD_FINISH,
    CMD_OUTPUT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] coef_sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic bad_op;
    logic zero_n;
    logic last_point;
    logic interior;
    logic quad_weight;
  } sts_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               ovf;
  } sval_t;

  function automatic sval_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    sval_t r;
    s = a + b;
    r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
    r.val = r.ovf ? (a[63] ? S64_MIN : S64_MAX) : s;
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Signed value from a sign and a magnitude, clamped to the 64-bit range.
  function automatic sval_t from_mag(logic neg, logic [63:0] m);
    sval_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (m[63] && (m[62:0] != '0)) begin
        r.ovf = 1'b1;
        r.val = S64_MIN;
      end else begin
        r.val = -$signed(m);
      end
    end else begin
      if (m[63]) begin
        r.ovf = 1'b1;
        r.val = S64_MAX;
      end else begin
        r.val = $signed(m);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/polynomial_definite_integrator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_definite_integrator_top
// Integrates a configurable cubic by the trapezoidal or Simpson rule.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// command   in         start / busy             in_i (pid_pkg::in_t)
// result    out        res_valid_o strobe       res_o (pid_pkg::out_t)
// config    in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A valid item holds busy for the division for the step width in the serial
// divider, each end and interior point (three Horner steps on the four-step
// multiplier), the scaling product, the division by the rule factor and the
// output, and the result strobe comes in the cycle busy falls.
// Invalid opcodes and a zero count hold busy for one cycle.
// Reset is asynchronous and needs no clearing pass. The result strobe lasts
// one cycle and cannot be held off.
module polynomial_definite_integrator_top #(
  parameter int MAX_DIVISIONS = 4096,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire pid_pkg::in_t   in_i,
  output logic                res_valid_o,
  output pid_pkg::out_t       res_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);
  import pid_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  pid_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  pid_dp #(
    .MAX_DIVISIONS (MAX_DIVISIONS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
`default_nettype wire

[hdl/pid_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_mul
// 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module pid_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  opa_i,
  input  wire logic [63:0]  opb_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);
  import pid_pkg::*;

  logic [63:0]  a_q, b_q, pp_q;
  logic [127:0] acc_q;
  logic [6:0]   sh_q, sh_d;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  a_part, b_part;

  // Step 0: low by low, steps 1 and 2: cross terms, step 3: high by high.
  always_comb begin
    a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    sh_d   = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0], 5'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= opa_i;
      b_q   <= opb_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= 64'(a_part) * 64'(b_part);
        sh_q <= sh_d;
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + ({64'b0, pp_q} << sh_q);
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

[hdl/pid_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_div
// Restoring divider, one quotient bit per cycle, 128-bit dividend.
// ----------------------------------------------------------------------------
module pid_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [127:0]                dividend_i,
  input  wire logic [pid_pkg::CNT_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [127:0]                     quot_o
);
  import pid_pkg::*;

  logic [127:0]     q_q;
  logic [CNT_W-1:0] rem_q, dv_q, rem_nx;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    trial  = {rem_q, q_q[127]};
    ge     = trial >= {1'b0, dv_q};
    rem_nx = ge ? CNT_W'(trial - {1'b0, dv_q}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[126:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule
`default_nettype wire

[hdl/pid_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_dp
// Datapath: coefficients, grid walk, Horner evaluation, weighted sum, scaling.
// ----------------------------------------------------------------------------
module pid_dp #(
  parameter int MAX_DIVISIONS = 4096,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pid_pkg::in_t   in_i,
  input  wire pid_pkg::cmd_t  cmd_i,
  output pid_pkg::sts_t       sts_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  output pid_pkg::out_t       res_o,
  output logic                res_valid_o
);
  import pid_pkg::*;

  localparam int LIM    = MAX_DIVISIONS - (MAX_DIVISIONS % 2);
  localparam int C3_RST = -((1 << FRAC_BITS) / 3);
  localparam int C2_RST = 1 << FRAC_BITS;
  localparam int C1_RST = 6 << FRAC_BITS;
  localparam int C0_RST = 100 << FRAC_BITS;
  localparam int SCL    = 3 * FRAC_BITS - 32;
  localparam int SR     = (SCL > 0) ? SCL : 0;
  localparam int SL     = (SCL < 0) ? -SCL : 0;

  logic signed [31:0] coef_q [4];

  logic signed [63:0] a_q, b_q, h2_q, pacc_q, x_q, y_q, acc_q;
  logic [CNT_W-1:0]   n_q, i_q, n_d;
  logic [1:0]         op_q;
  logic               neg_q, sat_q, out_v_q;
  out_t               res_q;

  logic               mul_start, div_start, mul_done, div_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod, quot, div_a, scaled;
  logic [CNT_W-1:0]   div_b;
  logic               scale_ovf;
  logic signed [63:0] d_s, x_d;
  sval_t              mq, madd, dbl, accs, fin;

  // Division by the rule factor, sixteen quotient bits a cycle.
  logic [127:0]       kq_q;
  logic [1:0]         kr_q, kr_d;
  logic [3:0]         kcnt_q;
  logic               kbusy_q, kdone_q, k_start;
  logic [17:0]        kcur;
  logic [35:0]        krecip;
  logic [15:0]        kdig;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[REG_CUBIC]    <= 32'(C3_RST);
      coef_q[REG_SQUARE]   <= 32'(C2_RST);
      coef_q[REG_LINEAR]   <= 32'(C1_RST);
      coef_q[REG_CONSTANT] <= 32'(C0_RST);
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    n_d = CNT_W'(in_i.divisions) + CNT_W'(in_i.divisions[0]);
    if (32'(n_d) > LIM) n_d = CNT_W'(LIM);
    d_s = 64'(b_q) - 64'(a_q);
    x_d = (i_q == n_q) ? b_q : a_q + (pacc_q >>> FRAC_BITS);

    // Product back to Q.F, clamped when bits remain above the 64-bit window.
    if (prod[127:64+FRAC_BITS] != '0) begin
      mq.ovf = 1'b1;
      mq.val = neg_q ? S64_MIN : S64_MAX;
    end else begin
      mq = from_mag(neg_q, prod[63+FRAC_BITS:FRAC_BITS]);
    end
    madd = sat_add(mq.val, 64'(coef_q[cmd_i.coef_sel]));
    dbl  = sat_add(y_q, y_q);
    accs = sat_add(acc_q, y_q);

    // h2 * S is in Q.3F; bring it to Q.32.
    scale_ovf = 1'b0;
    scaled    = (prod >> SR) << SL;
    if (SL > 0 && (prod >> (PROD_W - SL)) != '0) begin
      scale_ovf = 1'b1;
      scaled    = '1;
    end

    // One digit of the division by two or three; the remainder carried in is
    // below the divisor, so the quotient digit fits sixteen bits. Division by
    // three multiplies by (2^19 + 1) / 3, exact for values below 2^19.
    kcur   = {kr_q, kq_q[127:112]};
    krecip = 36'(kcur) * 36'd174763;
    if (op_q == OP_TRAP) begin
      kdig = kcur[16:1];
      kr_d = {1'b0, kcur[0]};
    end else begin
      kdig = krecip[34:19];
      kr_d = 2'(kcur - 18'(kdig) * 18'd3);
    end

    if (kq_q[127:64] != '0) begin
      fin.ovf = 1'b1;
      fin.val = neg_q ? S64_MIN : S64_MAX;
    end else begin
      fin = from_mag(neg_q, kq_q[63:0]);
    end

    mul_start = 1'b0;
    div_start = 1'b0;
    k_start   = 1'b0;
    mul_a     = mag64(y_q);
    mul_b     = mag64(x_q);
    div_a     = {64'b0, mag64(d_s)} << FRAC_BITS;
    div_b     = n_q;
    case (cmd_i.op)
      CMD_MUL:       mul_start = 1'b1;
      CMD_SCALE_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag64(h2_q);
        mul_b     = mag64(acc_q);
      end
      CMD_DIV_H2:    div_start = 1'b1;
      CMD_SCALE_DIV: k_start   = 1'b1;
      default: ;
    endcase
  end

  pid_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .opa_i   (mul_a),
    .opb_i   (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  pid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbusy_q <= 1'b0;
      kcnt_q  <= '0;
      kdone_q <= 1'b0;
    end else begin
      kdone_q <= 1'b0;
      if (k_start) begin
        kbusy_q <= 1'b1;
        kcnt_q  <= '0;
      end else if (kbusy_q) begin
        kcnt_q <= kcnt_q + 4'd1;
        if (kcnt_q == 4'd7) begin
          kbusy_q <= 1'b0;
          kdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_start) begin
      kq_q <= scaled;
      kr_q <= '0;
    end else if (kbusy_q) begin
      kq_q <= {kq_q[111:0], kdig};
      kr_q <= kr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= (cmd_i.op == CMD_OUTPUT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        a_q   <= 64'(in_i.lower_limit);
        b_q   <= 64'(in_i.upper_limit);
        op_q  <= in_i.opcode;
        n_q   <= n_d;
        sat_q <= 1'b0;
        res_q.integral       <= '0;
        res_q.divisions_used <= n_d[12:0];
        if (in_i.opcode != OP_TRAP && in_i.opcode != OP_SIMP) begin
          res_q.status <= ST_BAD_OP;
        end else if (n_d == '0) begin
          res_q.status <= ST_ZERO_N;
        end else begin
          res_q.status <= ST_OK;
        end
      end
      CMD_DIV_H2:  neg_q <= d_s[63];
      CMD_H2_DONE: begin
        h2_q   <= neg_q ? -$signed(quot[63:0]) : $signed(quot[63:0]);
        pacc_q <= '0;
        acc_q  <= '0;
        i_q    <= '0;
      end
      CMD_POINT: begin
        x_q <= x_d;
        y_q <= 64'(coef_q[REG_CUBIC]);
      end
      CMD_MUL:     neg_q <= y_q[63] ^ x_q[63];
      CMD_MUL_ADD: begin
        y_q   <= madd.val;
        sat_q <= sat_q | mq.ovf | madd.ovf;
      end
      CMD_DOUBLE: begin
        y_q   <= dbl.val;
        sat_q <= sat_q | dbl.ovf;
      end
      CMD_ACC: begin
        acc_q  <= accs.val;
        sat_q  <= sat_q | accs.ovf;
        pacc_q <= pacc_q + h2_q;
        i_q    <= i_q + CNT_W'(1);
      end
      CMD_SCALE_MUL: neg_q <= h2_q[63] ^ acc_q[63];
      CMD_SCALE_DIV: sat_q <= sat_q | scale_ovf;
      CMD_FINISH: begin
        res_q.integral <= fin.val;
        res_q.status   <= (sat_q | fin.ovf) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.mul_done    = mul_done;
    sts_o.div_done    = div_done || kdone_q;
    sts_o.bad_op      = (res_q.status == ST_BAD_OP);
    sts_o.zero_n      = (res_q.status == ST_ZERO_N);
    sts_o.last_point  = (i_q == n_q);
    sts_o.interior    = (i_q != '0) && (i_q != n_q);
    sts_o.quad_weight = (op_q == OP_SIMP) && i_q[0];
  end

  assign res_o       = res_q;
  assign res_valid_o = out_v_q;

endmodule
`default_nettype wire

[hdl/pid_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctrl
// Sequencer that steps the datapath through one integration.
// ----------------------------------------------------------------------------
module pid_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire pid_pkg::sts_t  sts_i,
  output pid_pkg::cmd_t       cmd_o,
  output logic                busy_o
);
  import pid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WAIT_H2, S_POINT, S_MUL, S_WAIT_MUL,
    S_WEIGHT, S_WEIGHT2, S_ACC, S_SCALE, S_WAIT_SM, S_WAIT_SD, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o.op       = CMD_NONE;
    cmd_o.coef_sel = REG_CUBIC;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.bad_op || sts_i.zero_n) begin
          cmd_o.op = CMD_OUTPUT;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = CMD_DIV_H2;
          state_d  = S_WAIT_H2;
        end
      end
      S_WAIT_H2: begin
        if (sts_i.div_done) begin
          cmd_o.op = CMD_H2_DONE;
          state_d  = S_POINT;
        end
      end
      S_POINT: begin
        cmd_o.op = CMD_POINT;
        step_d   = 2'd0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = CMD_MUL;
        state_d  = S_WAIT_MUL;
      end
      S_WAIT_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.op       = CMD_MUL_ADD;
          cmd_o.coef_sel = step_q + 2'd1;
          step_d         = step_q + 2'd1;
          state_d        = (step_q == 2'd2) ? S_WEIGHT : S_MUL;
        end
      end
      S_WEIGHT: begin
        if (sts_i.interior) begin
          cmd_o.op = CMD_DOUBLE;
          state_d  = S_WEIGHT2;
        end else begin
          state_d  = S_ACC;
        end
      end
      S_WEIGHT2: begin
        if (sts_i.quad_weight) cmd_o.op = CMD_DOUBLE;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = CMD_ACC;
        state_d  = sts_i.last_point ? S_SCALE : S_POINT;
      end
      S_SCALE: begin
        cmd_o.op = CMD_SCALE_MUL;
        state_d  = S_WAIT_SM;
      end
      S_WAIT_SM: begin
        if (sts_i.mul_done) begin
          cmd_o.op = CMD_SCALE_DIV;
          state_d  = S_WAIT_SD;
        end
      end
      S_WAIT_SD: begin
        if (sts_i.div_done) begin
          cmd_o.op = CMD_FINISH;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.op = CMD_OUTPUT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      busy_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      busy_o  <= (state_d != S_IDLE);
    end
  end

endmodule
`default_nettype wire

[hdl/pid_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks on command, result and busy behaviour.
// ----------------------------------------------------------------------------
module pid_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           res_valid_o,
  input wire pid_pkg::out_t  res_o
);
  import pid_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_fell_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("item finished without a result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_BAD_OP || res_o.status == ST_ZERO_N)
      |-> res_o.integral == '0)
    else $error("error result carries a non-zero integral");

endmodule

bind polynomial_definite_integrator_top pid_checker u_pid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives integration items into the polynomial integrator and compares every
// result with a bit-exact fixed-point prediction computed in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import pid_pkg::*;

  localparam int MAXN = 4096;
  localparam int FB   = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_i = '0;
  logic        res_valid_o;
  out_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  polynomial_definite_integrator_top DUT (
    .clk_i, .rst_ni, .start, .busy, .in_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  logic signed [63:0] coef [4];
  out_t expected_q [$];
  int   n_err = 0;
  bit   no_gaps = 1'b0;

  task automatic report(input string what);
    $display("tb_top: mismatch: %s", what);
    n_err++;
  endtask

  // Saturating helpers on 64-bit signed values, with a sticky flag.
  function automatic logic signed [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b,
                                               ref bit sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat = 1; return {1'b0, {63{1'b1}}}; end
    if (s < -65'sh0_8000_0000_0000_0000) begin sat = 1; return {1'b1, {63{1'b0}}}; end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_mag(bit neg, logic [127:0] m, ref bit sat);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) begin sat = 1; return {1'b1, {63{1'b0}}}; end
      return -$signed(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin sat = 1; return {1'b0, {63{1'b1}}}; end
    return m[63:0];
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b,
                                               ref bit sat);
    logic [127:0] p;
    p = (128'(abs64(a)) * 128'(abs64(b))) >> FB;
    return clamp_mag(a[63] != b[63], p, sat);
  endfunction

  function automatic logic signed [63:0] cubic_at(logic signed [63:0] x, ref bit sat);
    logic signed [63:0] y;
    y = coef[0];
    y = s_add(q_mul(y, x, sat), coef[1], sat);
    y = s_add(q_mul(y, x, sat), coef[2], sat);
    y = s_add(q_mul(y, x, sat), coef[3], sat);
    return y;
  endfunction

  function automatic out_t integrate(in_t it);
    out_t o;
    logic signed [63:0] a, b, h2, acc, x, t, fl;
    logic [13:0] n;
    logic [127:0] m;
    logic signed [127:0] prod;
    bit sat;
    sat = 0;
    a = 64'(it.lower_limit); b = 64'(it.upper_limit);
    n = 14'(it.divisions);
    if (n[0]) n++;
    if (n > MAXN) n = 14'(MAXN);
    o.integral = '0; o.divisions_used = n[12:0];
    if (it.opcode != OP_TRAP && it.opcode != OP_SIMP) begin
      o.status = ST_BAD_OP; return o;
    end
    if (n == 0) begin o.status = ST_ZERO_N; return o; end
    h2 = ((b - a) * 64'sd65536) / $signed(64'(n));
    acc = 0;
    for (int i = 0; i <= n; i++) begin
      prod = 128'(i) * 128'(h2);
      fl = 64'(prod >>> FB);
      x = (i == n) ? b : a + fl;
      t = cubic_at(x, sat);
      if (i != 0 && i != n) begin
        t = s_add(t, t, sat);
        if (it.opcode == OP_SIMP && i[0]) t = s_add(t, t, sat);
      end
      acc = s_add(acc, t, sat);
    end
    m = (128'(abs64(h2)) * 128'(abs64(acc))) >> (3 * FB - 32);
    m = m / ((it.opcode == OP_TRAP) ? 128'd2 : 128'd3);
    o.integral = clamp_mag(h2[63] != acc[63], m, sat);
    o.status = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  function automatic bit gap();
    return !no_gaps && ($urandom_range(99) < 31);
  endfunction

  task automatic send_item(input in_t it);
    while (gap()) @(posedge clk_i);
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(integrate(it));
    start <= 1'b0;
    // The block is busy in the cycle after an accepted item.
    @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    coef[idx] = 64'($signed(val));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The block is idle only once every result is in and it has dropped busy.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) report("result with nothing expected");
      else begin
        out_t e;
        e = expected_q.pop_front();
        if (res_o.integral !== e.integral)
          report($sformatf("integral %h, expected %h", res_o.integral, e.integral));
        if (res_o.divisions_used !== e.divisions_used)
          report($sformatf("divisions_used %0d, expected %0d",
                           res_o.divisions_used, e.divisions_used));
        if (res_o.status !== e.status)
          report($sformatf("status %0d, expected %0d", res_o.status, e.status));
      end
    end
  end

  function automatic in_t mk(int lo, int hi, int n, logic [1:0] op);
    in_t it;
    it.lower_limit = lo; it.upper_limit = hi; it.divisions = 13'(n); it.opcode = op;
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(0, 10 << FB, 10, OP_TRAP));
    send_item(mk(0, 10 << FB, 10, OP_SIMP));
    send_item(mk(0, 10 << FB, 7, OP_SIMP));            // odd count rounds up
    send_item(mk(0, 1 << FB, 0, OP_TRAP));             // zero count
    send_item(mk(0, 1 << FB, 0, 2'd0));                // bad opcode before zero count
    send_item(mk(0, 1 << FB, 5, 2'd3));
    send_item(mk(0, 1 << FB, 8191, OP_TRAP));          // clamped to the maximum
    send_item(mk(-(3 << FB), 2 << FB, 4096, OP_SIMP));
    send_item(mk(5 << FB, -(5 << FB), 4, OP_TRAP));    // reversed limits
    send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 2, OP_SIMP));
    send_item(mk(32'h7FFF_FFFF, 32'h8000_0000, 1, OP_TRAP));
    send_item(mk(7, 7, 2, OP_SIMP));
    drain();
  endtask

  task automatic test_coefs();
    write_coef(REG_CUBIC, 32'h8000_0000);
    write_coef(REG_SQUARE, 32'h7FFF_FFFF);
    write_coef(REG_LINEAR, 32'h8000_0000);
    write_coef(REG_CONSTANT, 32'h7FFF_FFFF);
    send_item(mk(0, 4 << FB, 4, OP_SIMP));
    send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 2, OP_TRAP));
    drain();
    write_coef(REG_CUBIC, 0);
    write_coef(REG_SQUARE, 0);
    write_coef(REG_LINEAR, 1 << FB);
    write_coef(REG_CONSTANT, 0);
    send_item(mk(0, 2 << FB, 2, OP_TRAP));
    send_item(mk(-(1 << FB), 1 << FB, 6, OP_SIMP));
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      for (int r = 0; r < 4; r++) write_coef(r[1:0], (phase == 3) ? $urandom :
                                         32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)));
      no_gaps = (phase == 2);
      for (int k = 0; k < 31; k++) begin
        in_t it;
        it.lower_limit = $urandom; it.upper_limit = $urandom;
        if ($urandom_range(3) != 0) begin
          it.lower_limit = $signed(it.lower_limit) >>> $urandom_range(8, 24);
          it.upper_limit = $signed(it.upper_limit) >>> $urandom_range(8, 24);
        end
        it.divisions = ($urandom_range(19) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40));
        it.opcode = ($urandom_range(9) == 0) ? 2'($urandom) :
                    ($urandom_range(1) ? OP_TRAP : OP_SIMP);
        send_item(it);
      end
      drain();
    end
  endtask

  initial begin
    coef[0] = -(64'sd65536 / 3);
    coef[1] = 64'sd1 <<< FB;
    coef[2] = 64'sd6 <<< FB;
    coef[3] = 64'sd100 <<< FB;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_coefs();
    test_random();
    if (n_err == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #(64'd20 * 64'd4_000_000);
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
